@@ src/cascaded_speed_current_pid_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded speed/current regulator
// Shared property forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef CASCADED_SPEED_CURRENT_PID_ASSERT_SVH
`define CASCADED_SPEED_CURRENT_PID_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSCPID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSCPID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/cscpid_pkg.sv @@
// ----------------------------------------------------------------------------
// cscpid_pkg
// Types, codes and constants of the cascaded speed/current regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package cscpid_pkg;

  // Default limits of the speed target.
  localparam int MAX_SPEED_DEF = 1536000;
  localparam int MIN_SPEED_DEF = 12800;

  // Fixed-point formats.
  localparam int SPEED_SHIFT   = 20;
  localparam int CURRENT_SHIFT = 28;
  localparam int VPRE_LIM      = 1073741823;

  // Iteration counts of the square root and the divider.
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 17;

  // Register values after reset.
  localparam logic [31:0] SPEED_KP_RST   = 32'd9395241;
  localparam logic [31:0] SPEED_KI_RST   = 32'd2684;
  localparam logic [31:0] SPEED_KD_RST   = 32'd0;
  localparam logic [31:0] CURRENT_KP_RST = 32'd9395241;
  localparam logic [31:0] CURRENT_KI_RST = 32'd2684;
  localparam logic [31:0] CURRENT_KD_RST = 32'd0;
  localparam logic [15:0] RAMP_STEP_RST  = 16'd256;
  localparam logic [22:0] MAX_TORQUE_RST = 23'd131072;

  typedef enum logic [2:0] {
    CMD_SET_SPEED, CMD_SET_TORQUE, CMD_SPEED_TICK, CMD_CURRENT_SAMPLE, CMD_CLEAR
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SPEED_KP, REG_SPEED_KI, REG_SPEED_KD, REG_CURRENT_KP,
    REG_CURRENT_KI, REG_CURRENT_KD, REG_RAMP_STEP, REG_MAX_TORQUE
  } reg_idx_t;

  typedef enum logic [1:0] {LOOP_SPEED, LOOP_D, LOOP_Q} loop_t;

  typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_SET_SPEED, OP_SET_TORQUE, OP_CLEAR, OP_RAMP,
    OP_PID_LOAD, OP_MUL, OP_ACC, OP_ROUND, OP_SAT, OP_SQ, OP_UACC,
    OP_SQRT_INIT, OP_SQRT_STEP, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE,
    OP_HOLD, OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_PID_LOAD, ST_MUL, ST_ACC, ST_ROUND, ST_SAT,
    ST_SQ_D, ST_UACC_D, ST_SQ_Q, ST_UACC_Q, ST_CHECK, ST_SQRT_INIT, ST_SQRT,
    ST_DIV_INIT, ST_DIV, ST_DIV_DONE, ST_HOLD, ST_EMIT
  } ctrl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t op;
    loop_t  loop;
    term_t  term;
    logic   half;
    logic   comp;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic big;
  } dp_status_t;

  // Configuration register contents.
  typedef struct packed {
    logic [31:0] speed_kp;
    logic [31:0] speed_ki;
    logic [31:0] speed_kd;
    logic [31:0] current_kp;
    logic [31:0] current_ki;
    logic [31:0] current_kd;
    logic [15:0] ramp_step;
    logic [22:0] max_torque;
  } cfg_t;

endpackage

`default_nettype wire

@@ src/cscpid_in_if.sv @@
// ----------------------------------------------------------------------------
// cscpid_in_if
// Input item channel: command and measurements, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cscpid_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [23:0] set_value;
  logic signed [23:0] measured_speed;
  logic signed [23:0] current_d;
  logic signed [23:0] current_q;

  modport source (output valid, cmd, set_value, measured_speed, current_d, current_q,
                  input ready);
  modport sink (input valid, cmd, set_value, measured_speed, current_d, current_q,
                output ready);
endinterface

`default_nettype wire

@@ src/cscpid_out_if.sv @@
// ----------------------------------------------------------------------------
// cscpid_out_if
// Result item channel: voltage vector and regulator state, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface cscpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] volt_d;
  logic signed [17:0] volt_q;
  logic signed [23:0] torque_out;
  logic signed [23:0] ramp_speed_out;

  modport source (output valid, volt_d, volt_q, torque_out, ramp_speed_out,
                  input ready);
  modport sink (input valid, volt_d, volt_q, torque_out, ramp_speed_out,
                output ready);
endinterface

`default_nettype wire

@@ src/cscpid_regs.sv @@
// ----------------------------------------------------------------------------
// cscpid_regs
// APB register file holding gains, ramp step and torque limit.
// ----------------------------------------------------------------------------
`default_nettype none

module cscpid_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cscpid_pkg::cfg_t   cfg
);
  import cscpid_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_kp   <= SPEED_KP_RST;
      cfg_r.speed_ki   <= SPEED_KI_RST;
      cfg_r.speed_kd   <= SPEED_KD_RST;
      cfg_r.current_kp <= CURRENT_KP_RST;
      cfg_r.current_ki <= CURRENT_KI_RST;
      cfg_r.current_kd <= CURRENT_KD_RST;
      cfg_r.ramp_step  <= RAMP_STEP_RST;
      cfg_r.max_torque <= MAX_TORQUE_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_SPEED_KP:   cfg_r.speed_kp   <= pwdata;
        REG_SPEED_KI:   cfg_r.speed_ki   <= pwdata;
        REG_SPEED_KD:   cfg_r.speed_kd   <= pwdata;
        REG_CURRENT_KP: cfg_r.current_kp <= pwdata;
        REG_CURRENT_KI: cfg_r.current_ki <= pwdata;
        REG_CURRENT_KD: cfg_r.current_kd <= pwdata;
        REG_RAMP_STEP:  cfg_r.ramp_step  <= pwdata[15:0];
        REG_MAX_TORQUE: cfg_r.max_torque <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      REG_SPEED_KP:   prdata = cfg_r.speed_kp;
      REG_SPEED_KI:   prdata = cfg_r.speed_ki;
      REG_SPEED_KD:   prdata = cfg_r.speed_kd;
      REG_CURRENT_KP: prdata = cfg_r.current_kp;
      REG_CURRENT_KI: prdata = cfg_r.current_ki;
      REG_CURRENT_KD: prdata = cfg_r.current_kd;
      REG_RAMP_STEP:  prdata = {16'b0, cfg_r.ramp_step};
      REG_MAX_TORQUE: prdata = {9'b0, cfg_r.max_torque};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ src/cscpid_dp.sv @@
// ----------------------------------------------------------------------------
// cscpid_dp
// Datapath: regulator state, one shared 24x32 multiplier, square root and
// divider, all stepped by commands from the controller.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascaded_speed_current_pid_assert.svh"

module cscpid_dp #(
  parameter int MAX_SPEED = cscpid_pkg::MAX_SPEED_DEF,
  parameter int MIN_SPEED = cscpid_pkg::MIN_SPEED_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cscpid_pkg::dp_cmd_t    cmd,
  output cscpid_pkg::dp_status_t status,
  input  cscpid_pkg::cfg_t       cfg,
  input  logic signed [23:0]     set_value,
  input  logic signed [23:0]     measured_speed,
  input  logic signed [23:0]     current_d,
  input  logic signed [23:0]     current_q,
  output logic signed [17:0]     volt_d,
  output logic signed [17:0]     volt_q,
  output logic signed [23:0]     torque_out,
  output logic signed [23:0]     ramp_speed_out
);
  import cscpid_pkg::*;

  localparam logic signed [24:0] MAX_S     = 25'(MAX_SPEED);
  localparam logic signed [24:0] MAX_S_NEG = -MAX_S;
  localparam logic signed [24:0] MIN_S     = 25'(MIN_SPEED);

  // Regulator state.
  logic signed [23:0] speed_target_r, speed_ramped_r, torque_ref_r;
  logic signed [24:0] prev_err_r [3];
  logic signed [47:0] integ_r [3];
  logic signed [17:0] vhold_d_r, vhold_q_r;

  // Captured item and working registers.
  logic signed [23:0] sv_r, meas_r, id_r, iq_r;
  logic signed [24:0] err_r;
  logic signed [25:0] delta_r;
  logic signed [47:0] acc_r;
  logic [55:0]        prod_r;
  logic               prod_neg_r, prod_hi_r;
  logic signed [81:0] sum_r;
  logic signed [61:0] rnd_r;
  logic signed [30:0] vd_r, vq_r;
  logic [61:0]        sq_r, u_r;
  logic [61:0]        sq_rem_r, sq_res_r, sq_bit_r;
  logic [32:0]        div_rem_r;
  logic [16:0]        div_num_r, div_q_r;
  logic               div_neg_r;
  logic signed [17:0] volt_d_r, volt_q_r;
  logic signed [23:0] torque_out_r, ramp_out_r;

  // Speed target with dead band and clamp.
  logic signed [24:0] sv_e, sv_abs;
  logic signed [23:0] target_nxt;
  always_comb begin
    sv_e   = 25'(sv_r);
    sv_abs = sv_e[24] ? -sv_e : sv_e;
    if (sv_abs < MIN_S)
      target_nxt = '0;
    else if (sv_e >= MAX_S)
      target_nxt = MAX_S[23:0];
    else if (sv_e <= MAX_S_NEG)
      target_nxt = MAX_S_NEG[23:0];
    else
      target_nxt = sv_r;
  end

  // Torque reference clamp on a set command.
  logic signed [24:0] mt_e, mt_neg;
  logic signed [23:0] torque_set_nxt;
  always_comb begin
    mt_e   = signed'({2'b0, cfg.max_torque});
    mt_neg = -mt_e;
    if (sv_e >= mt_e)
      torque_set_nxt = mt_e[23:0];
    else if (sv_e <= mt_neg)
      torque_set_nxt = mt_neg[23:0];
    else
      torque_set_nxt = sv_r;
  end

  // Speed ramp toward the target, stopping on it.
  logic signed [24:0] tgt_e, cur_e, st_e, up_diff, dn_diff;
  logic signed [23:0] ramp_nxt;
  always_comb begin
    tgt_e   = 25'(speed_target_r);
    cur_e   = 25'(speed_ramped_r);
    st_e    = signed'({9'b0, cfg.ramp_step});
    up_diff = tgt_e - cur_e;
    dn_diff = cur_e - tgt_e;
    if (tgt_e == '0 || (cur_e < 0 && tgt_e > 0) || (cur_e > 0 && tgt_e < 0))
      ramp_nxt = '0;
    else if (cur_e < tgt_e)
      ramp_nxt = (up_diff > st_e) ? 24'(cur_e + st_e) : speed_target_r;
    else if (cur_e > tgt_e)
      ramp_nxt = (dn_diff > st_e) ? 24'(cur_e - st_e) : speed_target_r;
    else
      ramp_nxt = speed_ramped_r;
  end

  // PID error, difference and saturated integral of the selected loop.
  logic signed [24:0] err_c, prev_c;
  logic signed [47:0] integ_c, acc_c;
  logic signed [25:0] delta_c;
  logic signed [48:0] isum;
  always_comb begin
    case (cmd.loop)
      LOOP_SPEED: begin
        err_c   = cur_e - 25'(meas_r);
        prev_c  = prev_err_r[0];
        integ_c = integ_r[0];
      end
      LOOP_D: begin
        err_c   = -25'(id_r);
        prev_c  = prev_err_r[1];
        integ_c = integ_r[1];
      end
      LOOP_Q: begin
        err_c   = 25'(torque_ref_r) - 25'(iq_r);
        prev_c  = prev_err_r[2];
        integ_c = integ_r[2];
      end
      default: begin
        err_c   = '0;
        prev_c  = '0;
        integ_c = '0;
      end
    endcase
    delta_c = 26'(err_c) - 26'(prev_c);
    isum    = 49'(integ_c) + 49'(err_c);
    if (isum[48] != isum[47])
      acc_c = isum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    else
      acc_c = isum[47:0];
  end

  // Partial product operand: one 24-bit half of a magnitude times a gain.
  logic signed [47:0] opnd;
  logic [47:0]        mag;
  logic [23:0]        part;
  logic [31:0]        gain;
  always_comb begin
    case (cmd.term)
      TERM_P:  opnd = 48'(err_r);
      TERM_I:  opnd = acc_r;
      TERM_D:  opnd = 48'(delta_r);
      default: opnd = '0;
    endcase
    mag  = opnd[47] ? (~opnd + 48'd1) : opnd;
    part = cmd.half ? mag[47:24] : mag[23:0];
    if (cmd.loop == LOOP_SPEED) begin
      case (cmd.term)
        TERM_P:  gain = cfg.speed_kp;
        TERM_I:  gain = cfg.speed_ki;
        TERM_D:  gain = cfg.speed_kd;
        default: gain = '0;
      endcase
    end else begin
      case (cmd.term)
        TERM_P:  gain = cfg.current_kp;
        TERM_I:  gain = cfg.current_ki;
        TERM_D:  gain = cfg.current_kd;
        default: gain = '0;
      endcase
    end
  end

  // Accumulation of the registered partial product.
  logic [81:0] ext;
  assign ext = prod_hi_r ? {2'b0, prod_r, 24'b0} : {26'b0, prod_r};

  // Round half up, shift, then saturate to the loop's limit.
  logic signed [81:0] s20, s28;
  logic signed [61:0] rnd_c, lim, lim_neg, sat_c;
  always_comb begin
    s20 = sum_r + (82'sd1 <<< (SPEED_SHIFT - 1));
    s28 = sum_r + (82'sd1 <<< (CURRENT_SHIFT - 1));
    if (cmd.loop == LOOP_SPEED) begin
      rnd_c = s20[81:SPEED_SHIFT];
      lim   = signed'({39'b0, cfg.max_torque});
    end else begin
      // The shifted sum is sign-extended to the working width.
      rnd_c = 62'(signed'(s28[81:CURRENT_SHIFT]));
      lim   = 62'(VPRE_LIM);
    end
    lim_neg = -lim;
    if (rnd_r > lim)
      sat_c = lim;
    else if (rnd_r < lim_neg)
      sat_c = lim_neg;
    else
      sat_c = rnd_r;
  end

  // Squares of the voltage components.
  logic signed [30:0] vsel;
  logic signed [61:0] sq_c;
  assign vsel = cmd.comp ? vq_r : vd_r;
  assign sq_c = vsel * vsel;

  assign status.big = (u_r > (62'd1 << 32));

  // One step of the bitwise square root.
  logic [61:0] sq_t;
  assign sq_t = sq_res_r + sq_bit_r;

  // One step of the restoring divider by the root.
  logic [32:0] div_r2, div_m;
  logic [30:0] vmag;
  logic signed [30:0] div_qs;
  always_comb begin
    div_r2 = {div_rem_r[31:0], div_num_r[16]};
    div_m  = {1'b0, sq_res_r[31:0]};
    vmag   = vsel[30] ? 31'(-vsel) : 31'(vsel);
    div_qs = div_neg_r ? -31'(div_q_r) : 31'(div_q_r);
  end

  // Regulator state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_target_r <= '0;
      speed_ramped_r <= '0;
      torque_ref_r   <= '0;
      vhold_d_r      <= '0;
      vhold_q_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_err_r[i] <= '0;
        integ_r[i]    <= '0;
      end
    end else begin
      case (cmd.op)
        OP_SET_SPEED:  speed_target_r <= target_nxt;
        OP_SET_TORQUE: torque_ref_r   <= torque_set_nxt;
        OP_RAMP:       speed_ramped_r <= ramp_nxt;
        OP_CLEAR: begin
          for (int i = 0; i < 3; i++) begin
            prev_err_r[i] <= '0;
            integ_r[i]    <= '0;
          end
        end
        OP_PID_LOAD: begin
          case (cmd.loop)
            LOOP_SPEED: begin
              prev_err_r[0] <= err_c;
              integ_r[0]    <= acc_c;
            end
            LOOP_D: begin
              prev_err_r[1] <= err_c;
              integ_r[1]    <= acc_c;
            end
            LOOP_Q: begin
              prev_err_r[2] <= err_c;
              integ_r[2]    <= acc_c;
            end
            default: ;
          endcase
        end
        OP_SAT: begin
          if (cmd.loop == LOOP_SPEED)
            torque_ref_r <= sat_c[23:0];
        end
        OP_HOLD: begin
          vhold_d_r <= vd_r[17:0];
          vhold_q_r <= vq_r[17:0];
        end
        default: ;
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        sv_r   <= set_value;
        meas_r <= measured_speed;
        id_r   <= current_d;
        iq_r   <= current_q;
      end
      OP_PID_LOAD: begin
        err_r   <= err_c;
        delta_r <= delta_c;
        acc_r   <= acc_c;
        sum_r   <= '0;
      end
      OP_MUL: begin
        prod_r     <= part * gain;
        prod_neg_r <= opnd[47];
        prod_hi_r  <= cmd.half;
      end
      OP_ACC:   sum_r <= prod_neg_r ? (sum_r - signed'(ext)) : (sum_r + signed'(ext));
      OP_ROUND: rnd_r <= rnd_c;
      OP_SAT: begin
        if (cmd.loop == LOOP_D)
          vd_r <= sat_c[30:0];
        else if (cmd.loop == LOOP_Q)
          vq_r <= sat_c[30:0];
      end
      OP_SQ: begin
        sq_r <= sq_c;
        if (!cmd.comp)
          u_r <= '0;
      end
      OP_UACC: u_r <= u_r + sq_r;
      OP_SQRT_INIT: begin
        sq_rem_r <= u_r;
        sq_res_r <= '0;
        sq_bit_r <= 62'd1 << 60;
      end
      OP_SQRT_STEP: begin
        if (sq_rem_r >= sq_t) begin
          sq_rem_r <= sq_rem_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
      end
      OP_DIV_INIT: begin
        div_rem_r <= 33'(vmag >> 1);
        div_num_r <= {vmag[0], 16'b0};
        div_q_r   <= '0;
        div_neg_r <= vsel[30];
      end
      OP_DIV_STEP: begin
        if (div_r2 >= div_m) begin
          div_rem_r <= div_r2 - div_m;
          div_q_r   <= {div_q_r[15:0], 1'b1};
        end else begin
          div_rem_r <= div_r2;
          div_q_r   <= {div_q_r[15:0], 1'b0};
        end
        div_num_r <= {div_num_r[15:0], 1'b0};
      end
      OP_DIV_DONE: begin
        if (cmd.comp)
          vq_r <= div_qs;
        else
          vd_r <= div_qs;
      end
      OP_EMIT: begin
        volt_d_r     <= vhold_d_r;
        volt_q_r     <= vhold_q_r;
        torque_out_r <= torque_ref_r;
        ramp_out_r   <= speed_ramped_r;
      end
      default: ;
    endcase
  end

  assign volt_d         = volt_d_r;
  assign volt_q         = volt_q_r;
  assign torque_out     = torque_out_r;
  assign ramp_speed_out = ramp_out_r;

  // Checks on the datapath.
  logic signed [24:0] tref_e;
  assign tref_e = 25'(torque_ref_r);

  `CSCPID_ASSERT_IMPL(a_vhold_range, 1'b1, (vhold_d_r >= -18'sd65536) && (vhold_d_r <= 18'sd65536) && (vhold_q_r >= -18'sd65536) && (vhold_q_r <= 18'sd65536), "held voltage outside unit circle range")
  `CSCPID_ASSERT_NEXT(a_torque_clamp, (cmd.op == OP_SAT) && (cmd.loop == LOOP_SPEED), (tref_e <= mt_e) && (tref_e >= mt_neg), "torque reference exceeds limit after speed PID")
  `CSCPID_ASSERT_IMPL(a_root_min, cmd.op == OP_DIV_INIT, sq_res_r >= 62'd65536, "divisor below unit length on circle limit")
  `CSCPID_ASSERT_IMPL(a_quot_range, cmd.op == OP_DIV_DONE, div_q_r <= 17'd65536, "scaled voltage component exceeds one")

endmodule

`default_nettype wire

@@ src/cscpid_ctrl.sv @@
// ----------------------------------------------------------------------------
// cscpid_ctrl
// Controller: sequences the datapath through each command and owns the
// input and result handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cascaded_speed_current_pid_assert.svh"

module cscpid_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_cmd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output cscpid_pkg::dp_cmd_t    dp_cmd,
  input  cscpid_pkg::dp_status_t status
);
  import cscpid_pkg::*;

  ctrl_state_t state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  loop_t       loop_r, loop_nxt;
  term_t       term_r, term_nxt;
  logic        half_r, half_nxt;
  logic        comp_r, comp_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and sequencing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cmd_r       <= CMD_SET_SPEED;
      loop_r      <= LOOP_SPEED;
      term_r      <= TERM_P;
      half_r      <= 1'b0;
      comp_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      loop_r      <= loop_nxt;
      term_r      <= term_nxt;
      half_r      <= half_nxt;
      comp_r      <= comp_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    loop_nxt      = loop_r;
    term_nxt      = term_r;
    half_nxt      = half_r;
    comp_nxt      = comp_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    dp_cmd.op     = OP_NONE;
    dp_cmd.loop   = loop_r;
    dp_cmd.term   = term_r;
    dp_cmd.half   = half_r;
    dp_cmd.comp   = comp_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.op = OP_CAPTURE;
          cmd_nxt   = cmd_t'(in_cmd);
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cmd_r)
          CMD_SET_SPEED: begin
            dp_cmd.op = OP_SET_SPEED;
            state_nxt = ST_EMIT;
          end
          CMD_SET_TORQUE: begin
            dp_cmd.op = OP_SET_TORQUE;
            state_nxt = ST_EMIT;
          end
          CMD_CLEAR: begin
            dp_cmd.op = OP_CLEAR;
            state_nxt = ST_EMIT;
          end
          CMD_SPEED_TICK: begin
            dp_cmd.op = OP_RAMP;
            loop_nxt  = LOOP_SPEED;
            state_nxt = ST_PID_LOAD;
          end
          CMD_CURRENT_SAMPLE: begin
            loop_nxt  = LOOP_D;
            state_nxt = ST_PID_LOAD;
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_PID_LOAD: begin
        dp_cmd.op = OP_PID_LOAD;
        term_nxt  = TERM_P;
        half_nxt  = 1'b0;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        dp_cmd.op = OP_MUL;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        dp_cmd.op = OP_ACC;
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = ST_MUL;
        end else begin
          half_nxt = 1'b0;
          if (term_r == TERM_D) begin
            state_nxt = ST_ROUND;
          end else begin
            term_nxt  = (term_r == TERM_P) ? TERM_I : TERM_D;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_ROUND: begin
        dp_cmd.op = OP_ROUND;
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        dp_cmd.op = OP_SAT;
        if (loop_r == LOOP_SPEED) begin
          state_nxt = ST_EMIT;
        end else if (loop_r == LOOP_D) begin
          loop_nxt  = LOOP_Q;
          state_nxt = ST_PID_LOAD;
        end else begin
          comp_nxt  = 1'b0;
          state_nxt = ST_SQ_D;
        end
      end
      ST_SQ_D: begin
        dp_cmd.op   = OP_SQ;
        dp_cmd.comp = 1'b0;
        state_nxt   = ST_UACC_D;
      end
      ST_UACC_D: begin
        dp_cmd.op = OP_UACC;
        state_nxt = ST_SQ_Q;
      end
      ST_SQ_Q: begin
        dp_cmd.op   = OP_SQ;
        dp_cmd.comp = 1'b1;
        state_nxt   = ST_UACC_Q;
      end
      ST_UACC_Q: begin
        dp_cmd.op = OP_UACC;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = status.big ? ST_SQRT_INIT : ST_HOLD;
      end
      ST_SQRT_INIT: begin
        dp_cmd.op = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        dp_cmd.op = OP_SQRT_STEP;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == 5'(SQRT_STEPS - 1)) begin
          comp_nxt  = 1'b0;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        dp_cmd.op = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        dp_cmd.op = OP_DIV_STEP;
        cnt_nxt   = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1))
          state_nxt = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        dp_cmd.op = OP_DIV_DONE;
        if (!comp_r) begin
          comp_nxt  = 1'b1;
          state_nxt = ST_DIV_INIT;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        dp_cmd.op = OP_HOLD;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // Load the result register once the previous result has left.
        if (!out_valid_r || out_ready) begin
          dp_cmd.op     = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  // Checks on the sequencing.
  `CSCPID_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_r == ST_DISPATCH, "accepted item did not start work")
  `CSCPID_ASSERT_IMPL(a_sqrt_count, state_r == ST_SQRT, cnt_r < 5'(SQRT_STEPS), "square root ran past its step count")
  `CSCPID_ASSERT_IMPL(a_div_count, state_r == ST_DIV, cnt_r < 5'(DIV_STEPS), "divider ran past its step count")
  `CSCPID_ASSERT_IMPL(a_result_source, $rose(out_valid_r), $past(state_r == ST_EMIT), "result appeared without an emit")

endmodule

`default_nettype wire

@@ src/cascaded_speed_current_pid.sv @@
// ----------------------------------------------------------------------------
// cascaded_speed_current_pid
// Cascaded speed/current regulator of a field-oriented drive, fixed point.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the next item is taken as soon as the
// previous one has been loaded into the result register, even if that result
// has not been taken yet. A speed tick runs one PID, made of the six partial
// products that one shared 24x32 multiplier needs per PID. A current sample
// runs two PIDs and the vector length check; when the vector is longer than
// one it adds a 31-step square root and a 17-step divider for each component.
`default_nettype none

module cascaded_speed_current_pid #(
  parameter int MAX_SPEED = cscpid_pkg::MAX_SPEED_DEF,
  parameter int MIN_SPEED = cscpid_pkg::MIN_SPEED_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cscpid_in_if.sink    in_ch,
  cscpid_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cscpid_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    dp_cmd;
  dp_status_t status;
  logic       in_ready, out_valid;

  // Configuration registers.
  cscpid_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer.
  cscpid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd),
    .status    (status)
  );

  // Arithmetic and regulator state.
  cscpid_dp #(
    .MAX_SPEED (MAX_SPEED),
    .MIN_SPEED (MIN_SPEED)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .status         (status),
    .cfg            (cfg),
    .set_value      (in_ch.set_value),
    .measured_speed (in_ch.measured_speed),
    .current_d      (in_ch.current_d),
    .current_q      (in_ch.current_q),
    .volt_d         (out_ch.volt_d),
    .volt_q         (out_ch.volt_q),
    .torque_out     (out_ch.torque_out),
    .ramp_speed_out (out_ch.ramp_speed_out)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

@@ tb/tb_cascaded_speed_current_pid.sv @@
// ----------------------------------------------------------------------------
// Testbench of the cascaded speed/current regulator
// Drives commands under random flow control, writes the gains and limits over
// APB between phases, and predicts every result item in fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_cascaded_speed_current_pid;
  import cscpid_pkg::*;

  typedef struct {
    logic [2:0]         cmd;
    logic signed [23:0] set_value;
    logic signed [23:0] meas_speed;
    logic signed [23:0] cur_d;
    logic signed [23:0] cur_q;
  } drive_item_t;

  typedef struct packed {
    logic signed [17:0] volt_d;
    logic signed [17:0] volt_q;
    logic signed [23:0] torque;
    logic signed [23:0] ramp_speed;
  } regulator_out_t;

  localparam longint INTEG_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  // Regulator state mirror and queue of expected result items.
  class regulator_scoreboard;
    logic [31:0]    gain[6];
    logic [15:0]    ramp_step;
    logic [22:0]    max_torque;
    longint         target, ramped, torque;
    longint         prev_err[3], integ[3], vhold[2];
    regulator_out_t awaited[$];
    int             errors, results, items;

    function new();
      gain[REG_SPEED_KP] = SPEED_KP_RST;   gain[REG_SPEED_KI] = SPEED_KI_RST;
      gain[REG_SPEED_KD] = SPEED_KD_RST;   gain[REG_CURRENT_KP] = CURRENT_KP_RST;
      gain[REG_CURRENT_KI] = CURRENT_KI_RST; gain[REG_CURRENT_KD] = CURRENT_KD_RST;
      ramp_step = RAMP_STEP_RST;
      max_torque = MAX_TORQUE_RST;
      target = 0; ramped = 0; torque = 0;
      clear_history();
      vhold[0] = 0; vhold[1] = 0;
      errors = 0; results = 0; items = 0;
    endfunction

    function void clear_history();
      for (int i = 0; i < 3; i++) begin
        prev_err[i] = 0;
        integ[i] = 0;
      end
    endfunction

    // One PID step: exact sum of products, round half up, saturate.
    function longint run_pid(int k, longint err, logic [31:0] kp, logic [31:0] ki,
                             logic [31:0] kd, int shift, longint lim);
      longint             delta, acc;
      logic signed [127:0] sum, e, a, dl;
      delta = err - prev_err[k];
      acc = integ[k] + err;
      if (acc > INTEG_MAX) acc = INTEG_MAX;
      if (acc < INTEG_MIN) acc = INTEG_MIN;
      prev_err[k] = err;
      integ[k] = acc;
      e = err; a = acc; dl = delta;
      sum = e * $signed({96'd0, kp}) + a * $signed({96'd0, ki}) +
            dl * $signed({96'd0, kd});
      sum = (sum + (128'sd1 <<< (shift - 1))) >>> shift;
      if (sum > lim) return lim;
      if (sum < -lim) return -lim;
      return longint'(sum);
    endfunction

    function longint unsigned int_sqrt(longint unsigned u);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > u) bitv >>= 2;
      while (bitv != 0) begin
        if (u >= res + bitv) begin
          u -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Applies one accepted input item and queues its result.
    function void note_input(drive_item_t it);
      longint         sv, mt, st, vd, vq, m;
      longint unsigned u;
      regulator_out_t exp_out;
      sv = it.set_value;
      mt = max_torque;
      items++;
      case (it.cmd)
        CMD_SET_SPEED: begin
          if ((sv < 0 ? -sv : sv) < MIN_SPEED_DEF) target = 0;
          else if (sv >= MAX_SPEED_DEF) target = MAX_SPEED_DEF;
          else if (sv <= -MAX_SPEED_DEF) target = -MAX_SPEED_DEF;
          else target = sv;
        end
        CMD_SET_TORQUE: torque = (sv >= mt) ? mt : (sv <= -mt) ? -mt : sv;
        CMD_SPEED_TICK: begin
          st = ramp_step;
          if (target == 0 || (ramped < 0 && target > 0) || (ramped > 0 && target < 0))
            ramped = 0;
          else if (ramped < target)
            ramped = (target - ramped > st) ? ramped + st : target;
          else if (ramped > target)
            ramped = (ramped - target > st) ? ramped - st : target;
          torque = run_pid(LOOP_SPEED, ramped - longint'(it.meas_speed),
                           gain[REG_SPEED_KP], gain[REG_SPEED_KI], gain[REG_SPEED_KD],
                           SPEED_SHIFT, mt);
        end
        CMD_CURRENT_SAMPLE: begin
          vd = run_pid(LOOP_D, -longint'(it.cur_d), gain[REG_CURRENT_KP],
                       gain[REG_CURRENT_KI], gain[REG_CURRENT_KD], CURRENT_SHIFT, VPRE_LIM);
          vq = run_pid(LOOP_Q, torque - longint'(it.cur_q), gain[REG_CURRENT_KP],
                       gain[REG_CURRENT_KI], gain[REG_CURRENT_KD], CURRENT_SHIFT, VPRE_LIM);
          u = vd * vd + vq * vq;
          if (u > (64'd1 << 32)) begin
            m = int_sqrt(u);
            vd = (vd * 65536) / m;
            vq = (vq * 65536) / m;
          end
          vhold[0] = vd;
          vhold[1] = vq;
        end
        CMD_CLEAR: clear_history();
        default: ;
      endcase
      exp_out.volt_d = vhold[0][17:0];
      exp_out.volt_q = vhold[1][17:0];
      exp_out.torque = torque[23:0];
      exp_out.ramp_speed = ramped[23:0];
      awaited.push_back(exp_out);
    endfunction

    function void check_result(regulator_out_t got);
      regulator_out_t want;
      results++;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result item %p", got);
        return;
      end
      want = awaited.pop_front();
      if (got.volt_d !== want.volt_d || got.volt_q !== want.volt_q ||
          got.torque !== want.torque || got.ramp_speed !== want.ramp_speed) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result %0d: vd %0d/%0d vq %0d/%0d torque %0d/%0d ramp %0d/%0d",
                   results, want.volt_d, got.volt_d, want.volt_q, got.volt_q,
                   want.torque, got.torque, want.ramp_speed, got.ramp_speed);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          send_idle_pct, recv_stall_pct;

  cscpid_in_if  in_if();
  cscpid_out_if out_if();

  regulator_scoreboard sb = new();

  cascaded_speed_current_pid uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_cascaded_speed_current_pid: errors");
    $finish;
  end

  // Result side: random back-pressure and checking of every accepted item.
  always @(posedge clk) begin
    if (out_if.valid && out_if.ready)
      sb.check_result({out_if.volt_d, out_if.volt_q, out_if.torque_out,
                       out_if.ramp_speed_out});
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    logic rdy;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(4 * int'(r)); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (r == REG_RAMP_STEP) sb.ramp_step = v[15:0];
    else if (r == REG_MAX_TORQUE) sb.max_torque = v[22:0];
    else sb.gain[r] = v;
  endtask

  task automatic write_all(logic [31:0] g[6], logic [15:0] step, logic [22:0] mt);
    for (int i = 0; i < 6; i++) write_reg(reg_idx_t'(i), g[i]);
    write_reg(REG_RAMP_STEP, {16'd0, step});
    write_reg(REG_MAX_TORQUE, {9'd0, mt});
  endtask

  // Sends one item; returns after the edge at which it was accepted.
  task automatic send_item(drive_item_t it);
    logic rdy;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.cmd <= it.cmd;
    in_if.set_value <= it.set_value;
    in_if.measured_speed <= it.meas_speed;
    in_if.current_d <= it.cur_d;
    in_if.current_q <= it.cur_q;
    do begin
      @(negedge clk);
      rdy = in_if.ready;
      @(posedge clk);
    end while (!rdy);
    sb.note_input(it);
  endtask

  task automatic send(logic [2:0] cmd, longint sv, longint ms, longint cd, longint cq);
    drive_item_t it;
    it.cmd = cmd;
    it.set_value = sv[23:0];
    it.meas_speed = ms[23:0];
    it.cur_d = cd[23:0];
    it.cur_q = cq[23:0];
    send_item(it);
  endtask

  // Lets the pipeline drain before the registers are touched.
  task automatic drain();
    in_if.valid <= 1'b0;
    wait (sb.awaited.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  function automatic longint any24();
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic longint near(longint c, int span);
    longint v;
    v = c + $signed($urandom_range(2 * span)) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  // Mostly well-formed control traffic, with some raw noise mixed in.
  task automatic random_items(int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 30)
        send(CMD_SPEED_TICK, any24(), near(sb.ramped, 20000), any24(), any24());
      else if (pick < 65)
        send(CMD_CURRENT_SAMPLE, any24(), any24(), near(0, 200000),
             near(sb.torque, 200000));
      else if (pick < 77)
        send(CMD_SET_SPEED, near(0, 1600000), any24(), any24(), any24());
      else if (pick < 87)
        send(CMD_SET_TORQUE, near(0, 300000), any24(), any24(), any24());
      else if (pick < 91)
        send(CMD_CLEAR, any24(), any24(), any24(), any24());
      else
        send(3'($urandom_range(7)), any24(), any24(), any24(), any24());
    end
  endtask

  initial begin
    logic [31:0] g[6];
    rst_n <= 1'b0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_if.valid <= 1'b0; in_if.cmd <= '0; in_if.set_value <= '0;
    in_if.measured_speed <= '0; in_if.current_d <= '0; in_if.current_q <= '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dead band and clamp edges, ramp, torque clamp, circle limit.
    send(CMD_SET_SPEED, MIN_SPEED_DEF - 1, 0, 0, 0);
    send(CMD_SET_SPEED, -MIN_SPEED_DEF, 0, 0, 0);
    send(CMD_SPEED_TICK, 0, 0, 0, 0);
    send(CMD_SET_SPEED, 8388607, 0, 0, 0);
    send(CMD_SPEED_TICK, 0, -8388608, 0, 0);
    send(CMD_SPEED_TICK, 0, 8388607, 0, 0);
    send(CMD_SET_SPEED, -8388608, 0, 0, 0);
    send(CMD_SPEED_TICK, 0, 0, 0, 0);
    send(CMD_SET_SPEED, -MAX_SPEED_DEF, 0, 0, 0);
    send(CMD_SPEED_TICK, 0, 0, 0, 0);
    send(CMD_SET_SPEED, -MIN_SPEED_DEF - 100, 0, 0, 0);
    send(CMD_SPEED_TICK, 0, 0, 0, 0);
    send(CMD_SET_TORQUE, 8388607, 0, 0, 0);
    send(CMD_SET_TORQUE, -8388608, 0, 0, 0);
    send(CMD_SET_TORQUE, 1000, 0, 0, 0);
    send(CMD_CURRENT_SAMPLE, 0, 0, 8388607, -8388608);
    send(CMD_CURRENT_SAMPLE, 0, 0, -8388608, 8388607);
    send(CMD_CURRENT_SAMPLE, 0, 0, 1000, -1000);
    send(CMD_CLEAR, 0, 0, 0, 0);
    for (int c = int'(CMD_CLEAR) + 1; c < 8; c++) send(3'(c), -1, -1, -1, -1);
    drain();

    // Mid-range gains with a lazy sender and a slow receiver.
    send_idle_pct = 6;
    recv_stall_pct = 45;
    for (int i = 0; i < 6; i++) g[i] = $urandom_range(32'h0400_0000);
    write_all(g, 16'($urandom_range(4000)), 23'($urandom_range(400000)));
    random_items(400);
    drain();

    // All registers at their maximum.
    send_idle_pct = 45;
    recv_stall_pct = 6;
    for (int i = 0; i < 6; i++) g[i] = 32'hFFFF_FFFF;
    write_all(g, 16'hFFFF, 23'h7F_FFFF);
    random_items(150);
    drain();

    // All registers at zero.
    for (int i = 0; i < 6; i++) g[i] = 32'd0;
    write_all(g, 16'd0, 23'd0);
    random_items(100);
    drain();

    // Reset P and I gains, random D gains, no flow control at all.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    g[0] = SPEED_KP_RST;   g[1] = SPEED_KI_RST;   g[2] = 32'($urandom);
    g[3] = CURRENT_KP_RST; g[4] = CURRENT_KI_RST; g[5] = 32'($urandom_range(65535));
    write_all(g, 16'($urandom_range(1, 65535)), MAX_TORQUE_RST);
    random_items(450);
    in_if.valid <= 1'b0;
    wait (sb.awaited.size() == 0);
    repeat (150) @(posedge clk);

    $display("Covered %0d input items and %0d result items over five register settings.",
             sb.items, sb.results);
    $display("Mismatches seen: %0d.", sb.errors);
    if (sb.errors == 0 && sb.awaited.size() == 0)
      $display("tb_cascaded_speed_current_pid: clean");
    else
      $display("tb_cascaded_speed_current_pid: errors");
    $finish;
  end
endmodule
